FILE: src/bbsc_pkg.sv
// Shared types and constants for the bracket balance and spacing checker.
// No dependencies; imported by the stack cell and the top level.
package bbsc_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic KIND_BRACE = 1'b0;
  localparam logic KIND_BRACK = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

FILE: src/bbsc_cell.sv
// One cell of the shifting opener stack: holds the kind of one open bracket.
// Depends on bbsc_pkg for the shift control struct.
module bbsc_cell (
  input  logic                clk,
  input  bbsc_pkg::cell_ctrl_t ctrl,
  input  logic                from_up,
  input  logic                from_down,
  output logic                kind_q
);
  import bbsc_pkg::*;

  logic kind_r;
  logic kind_nxt;

  always_comb begin
    kind_nxt = kind_r;
    if (ctrl.push) begin
      kind_nxt = from_up;
    end else if (ctrl.pop) begin
      kind_nxt = from_down;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind_q = kind_r;

endmodule

FILE: src/bracket_balance_spacing_checker_core.sv
// The result word for an end item is registered and appears in the cycle after that item is accepted.
// One input word is accepted per cycle while in_stall is low; a push or pop shifts the whole cell row together.
// An end item is held off only while an earlier result word is still stalled at the output.
// Reset: synchronous active-low rst_n clears the depth, error and spacing flags and output valid,
// and sets at_start_r; stack cells hold no reset and are only read below the current depth.
// Depends on bbsc_pkg and bbsc_cell.
module bracket_balance_spacing_checker_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res
);
  import bbsc_pkg::*;

  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               err_r, err_nxt;
  logic               at_start_r, at_start_nxt;
  logic               prev_space_r, prev_space_nxt;
  logic               need_space_r, need_space_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_res_r, out_res_nxt;

  logic               accept;
  logic               is_open, is_close, is_space, kind;
  logic               can_push, can_pop;
  cell_ctrl_t         ctrl;
  logic [STACK_DEPTH-1:0] cell_q, up_in, down_in;

  assign in_stall = out_valid_r & out_stall & (in_mode == MODE_END);
  assign accept   = in_valid & ~in_stall;

  assign is_open  = (in_ch == CH_LBRACE) | (in_ch == CH_LBRACK);
  assign is_close = (in_ch == CH_RBRACE) | (in_ch == CH_RBRACK);
  assign is_space = (in_ch == CH_SPACE);
  assign kind     = ((in_ch == CH_LBRACK) | (in_ch == CH_RBRACK)) ? KIND_BRACK : KIND_BRACE;
  assign can_push = (depth_r < DEPTH_W'(STACK_DEPTH));
  assign can_pop  = (depth_r != '0);

  assign ctrl.push = accept & (in_mode == MODE_CHAR) & is_open & can_push;
  assign ctrl.pop  = accept & (in_mode == MODE_CHAR) & is_close & can_pop;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign up_in[gi] = kind;
      end else begin : g_mid
        assign up_in[gi] = cell_q[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_last
        assign down_in[gi] = 1'b0;
      end else begin : g_inner
        assign down_in[gi] = cell_q[gi+1];
      end
      bbsc_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .from_up   (up_in[gi]),
        .from_down (down_in[gi]),
        .kind_q    (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    depth_nxt      = depth_r;
    err_nxt        = err_r;
    at_start_nxt   = at_start_r;
    prev_space_nxt = prev_space_r;
    need_space_nxt = need_space_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_res_nxt    = out_res_r;
    if (accept) begin
      if (in_mode == MODE_END) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = ~err_r & (depth_r == '0);
        depth_nxt      = '0;
        err_nxt        = 1'b0;
        at_start_nxt   = 1'b1;
        prev_space_nxt = 1'b0;
        need_space_nxt = 1'b0;
      end else begin
        if (need_space_r & ~is_space) begin
          err_nxt = 1'b1;
        end
        if ((is_open | is_close) & ~at_start_r & ~prev_space_r) begin
          err_nxt = 1'b1;
        end
        if (is_open) begin
          if (can_push) begin
            depth_nxt = depth_r + DEPTH_W'(1);
          end else begin
            err_nxt = 1'b1;
          end
        end else if (is_close) begin
          if (can_pop) begin
            depth_nxt = depth_r - DEPTH_W'(1);
            if (cell_q[0] != kind) begin
              err_nxt = 1'b1;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
        need_space_nxt = is_open | is_close;
        prev_space_nxt = is_space;
        at_start_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= '0;
      err_r        <= 1'b0;
      at_start_r   <= 1'b1;
      prev_space_r <= 1'b0;
      need_space_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      depth_r      <= depth_nxt;
      err_r        <= err_nxt;
      at_start_r   <= at_start_nxt;
      prev_space_r <= prev_space_nxt;
      need_space_r <= need_space_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_END) |=> (depth_r == '0 && at_start_r && !err_r && out_valid_r))
    else $error("end word did not clear state or raise a result");

  a_err_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_END && err_r) |=> !out_valid_res)
    else $error("result high after a rule was broken");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |=> depth_r == $past(depth_r) + DEPTH_W'(1))
    else $error("push did not advance depth");
`endif

endmodule
